// ===== design/m3inv_pkg.sv =====
// Shared widths and the cofactor index table for the 3x3 matrix inverter.
// Depends on nothing; used by m3inv_div and matrix3_inverse.
`timescale 1ns / 1ps
package m3inv_pkg;
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int PROD_W    = 2 * WORD_BITS;
   localparam int COF_W     = 2 * WORD_BITS + 1;
   localparam int PART_W    = 2 * WORD_BITS + 1;
   localparam int DET_W     = 3 * WORD_BITS + 3;
   localparam int NUM_W     = COF_W + 2 * FRAC_BITS;
   localparam int REM_W     = DET_W + WORD_BITS + 1;
   localparam int THR_W     = 31;
   localparam int DIV_STAGES = WORD_BITS + 2;
   localparam int PRE_STAGES = 6;
   localparam int NUM_STAGES = PRE_STAGES + DIV_STAGES;

   typedef logic [3:0] idx_type;
   localparam idx_type COF_IDX [9][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
   };
endpackage

// ===== design/m3inv_div.sv =====
// Pipelined restoring divider with saturation for one inverse element.
// Depends on m3inv_pkg; stage enables come from the top level.
`timescale 1ns / 1ps
module m3inv_div (
   input  logic                                   clock,
   input  logic [m3inv_pkg::DIV_STAGES-1:0]       en,
   input  logic [m3inv_pkg::NUM_W-1:0]            num,
   input  logic [m3inv_pkg::DET_W-1:0]            den,
   input  logic                                   neg,
   input  logic                                   zero,
   output logic [m3inv_pkg::WORD_BITS-1:0]        result
);
   localparam int W = m3inv_pkg::WORD_BITS;
   localparam logic [W-1:0] LIM = W'(1) << (W - 1);

   logic [m3inv_pkg::REM_W-1:0] rem_ff  [W+1];
   logic [m3inv_pkg::DET_W-1:0] den_ff  [W+1];
   logic [W-1:0]                q_ff    [W+1];
   logic                        neg_ff  [W+1];
   logic                        zero_ff [W+1];
   logic                        over_ff [W+1];
   logic [W-1:0]                result_ff;
   logic [W-1:0]                result_in;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0]  <= m3inv_pkg::REM_W'(num);
         den_ff[0]  <= den;
         q_ff[0]    <= '0;
         neg_ff[0]  <= neg;
         zero_ff[0] <= zero;
         over_ff[0] <= m3inv_pkg::REM_W'(num) >= (m3inv_pkg::REM_W'(den) << W);
      end
   end

   for (genvar k = 1; k <= W; k++) begin : g_step
      logic [m3inv_pkg::REM_W-1:0] dsh;
      logic                        take;
      assign dsh  = m3inv_pkg::REM_W'(den_ff[k-1]) << (W - k);
      assign take = rem_ff[k-1] >= dsh;
      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k]  <= take ? rem_ff[k-1] - dsh : rem_ff[k-1];
            q_ff[k]    <= q_ff[k-1] | (take ? (W'(1) << (W - k)) : '0);
            den_ff[k]  <= den_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
            over_ff[k] <= over_ff[k-1];
         end
      end
   end

   always_comb begin
      if (zero_ff[W]) begin
         result_in = '0;
      end else if (neg_ff[W]) begin
         result_in = (over_ff[W] || q_ff[W] > LIM) ? LIM : -q_ff[W];
      end else begin
         result_in = (over_ff[W] || q_ff[W] > LIM - W'(1)) ? LIM - W'(1) : q_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (en[W+1]) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;
endmodule

// ===== design/matrix3_inverse.sv =====
// Top level of the 3x3 fixed-point matrix inverter: cofactors, determinant,
// singular test and nine dividers. Depends on m3inv_pkg and m3inv_div.
//
// A matrix arrives as one transaction on the req_ channel (nine signed
// Q16.16 elements, row-major) and leaves as one transaction on the rsp_
// channel: the nine inverse elements and the singular flag. When the
// determinant magnitude in Q16.16 is below the threshold register, or the
// determinant is zero, singular is set and all elements are zero.
// Between acceptance and rsp_valid lie 6 stages of products, cofactors and
// determinant, one divider set-up stage, 32 single-bit division stages and
// the saturation register. One transaction is accepted per cycle unless
// stalled; the rate is set by the divider pipeline, one quotient bit per
// stage. Every stage holds its transaction while the stages after it are
// full and the receiver stalls; a stage with a bubble keeps accepting, so
// req_ready stays high until the whole pipeline is full. Reset clears all
// valid bits and sets the threshold to 1. The threshold must be written
// through csr_write_enable and csr_det_threshold while idle (not enforced).
`timescale 1ns / 1ps
module matrix3_inverse (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [m3inv_pkg::THR_W-1:0]           csr_det_threshold,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [m3inv_pkg::WORD_BITS-1:0] req_r0c0,
   input  logic signed [m3inv_pkg::WORD_BITS-1:0] req_r0c1,
   input  logic signed [m3inv_pkg::WORD_BITS-1:0] req_r0c2,
   input  logic signed [m3inv_pkg::WORD_BITS-1:0] req_r1c0,
   input  logic signed [m3inv_pkg::WORD_BITS-1:0] req_r1c1,
   input  logic signed [m3inv_pkg::WORD_BITS-1:0] req_r1c2,
   input  logic signed [m3inv_pkg::WORD_BITS-1:0] req_r2c0,
   input  logic signed [m3inv_pkg::WORD_BITS-1:0] req_r2c1,
   input  logic signed [m3inv_pkg::WORD_BITS-1:0] req_r2c2,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [m3inv_pkg::WORD_BITS-1:0] rsp_r0c0,
   output logic signed [m3inv_pkg::WORD_BITS-1:0] rsp_r0c1,
   output logic signed [m3inv_pkg::WORD_BITS-1:0] rsp_r0c2,
   output logic signed [m3inv_pkg::WORD_BITS-1:0] rsp_r1c0,
   output logic signed [m3inv_pkg::WORD_BITS-1:0] rsp_r1c1,
   output logic signed [m3inv_pkg::WORD_BITS-1:0] rsp_r1c2,
   output logic signed [m3inv_pkg::WORD_BITS-1:0] rsp_r2c0,
   output logic signed [m3inv_pkg::WORD_BITS-1:0] rsp_r2c1,
   output logic signed [m3inv_pkg::WORD_BITS-1:0] rsp_r2c2,
   output logic                                  rsp_singular
);
   localparam int W  = m3inv_pkg::WORD_BITS;
   localparam int F  = m3inv_pkg::FRAC_BITS;
   localparam int NS = m3inv_pkg::NUM_STAGES;
   localparam int PS = m3inv_pkg::PRE_STAGES;
   localparam int DW = m3inv_pkg::DET_W;
   localparam int CW = m3inv_pkg::COF_W;

   logic signed [W-1:0]                   m [9];
   logic [NS-1:0]                         v_ff;
   logic [NS-1:0]                         en;
   logic [m3inv_pkg::THR_W-1:0]           thr_ff;

   logic signed [m3inv_pkg::PROD_W-1:0]   p_ff [18];
   logic signed [W-1:0]                   m0_ff [3];
   logic signed [W-1:0]                   m1_ff [3];
   logic signed [CW-1:0]                  cof1_ff [9];
   logic signed [m3inv_pkg::PART_W-1:0]   pl_ff [3];
   logic signed [m3inv_pkg::PART_W-1:0]   ph_ff [3];
   logic signed [CW-1:0]                  cof2_ff [9];
   logic signed [DW-1:0]                  t_ff [3];
   logic signed [CW-1:0]                  cof3_ff [9];
   logic signed [DW-1:0]                  det_ff;
   logic signed [CW-1:0]                  cof4_ff [9];
   logic [DW-1:0]                         dabs_in;
   logic [DW-1:0]                         dabs_ff;
   logic [m3inv_pkg::NUM_W-1:0]           num_ff [9];
   logic                                  neg_ff [9];
   logic [NS-1:PS-1]                      sing_ff;
   logic [W-1:0]                          res [9];

   assign m = '{req_r0c0, req_r0c1, req_r0c2, req_r1c0, req_r1c1,
                req_r1c2, req_r2c0, req_r2c1, req_r2c2};

   always_comb begin
      for (int s = 0; s < NS; s++) begin
         en[s] = rsp_ready || |(~v_ff & ~((NS'(1) << s) - NS'(1)));
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff   <= '0;
         thr_ff <= m3inv_pkg::THR_W'(1);
      end else begin
         if (csr_write_enable) begin
            thr_ff <= csr_det_threshold;
         end
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int s = 1; s < NS; s++) begin
            if (en[s]) begin
               v_ff[s] <= v_ff[s-1];
            end
         end
      end
   end

   for (genvar k = 0; k < 9; k++) begin : g_cof
      always_ff @(posedge clock) begin
         if (en[0]) begin
            p_ff[2*k]   <= m[m3inv_pkg::COF_IDX[k][0]] * m[m3inv_pkg::COF_IDX[k][1]];
            p_ff[2*k+1] <= m[m3inv_pkg::COF_IDX[k][2]] * m[m3inv_pkg::COF_IDX[k][3]];
         end
         if (en[1]) cof1_ff[k] <= CW'(p_ff[2*k]) - CW'(p_ff[2*k+1]);
         if (en[2]) cof2_ff[k] <= cof1_ff[k];
         if (en[3]) cof3_ff[k] <= cof2_ff[k];
         if (en[4]) cof4_ff[k] <= cof3_ff[k];
         if (en[5]) begin
            neg_ff[k] <= cof4_ff[k][CW-1] ^ det_ff[DW-1];
            num_ff[k] <= m3inv_pkg::NUM_W'(cof4_ff[k][CW-1] ? -cof4_ff[k] : cof4_ff[k])
                         << (2 * F);
         end
      end
   end

   for (genvar j = 0; j < 3; j++) begin : g_det
      always_ff @(posedge clock) begin
         if (en[0]) m0_ff[j] <= m[j];
         if (en[1]) m1_ff[j] <= m0_ff[j];
         if (en[2]) begin
            pl_ff[j] <= m1_ff[j] * $signed({1'b0, cof1_ff[3*j][W-1:0]});
            ph_ff[j] <= m1_ff[j] * $signed(cof1_ff[3*j][CW-1:W]);
         end
         if (en[3]) t_ff[j] <= (DW'(ph_ff[j]) <<< W) + DW'(pl_ff[j]);
      end
   end

   assign dabs_in = det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);

   always_ff @(posedge clock) begin
      if (en[4]) det_ff <= t_ff[0] + t_ff[1] + t_ff[2];
      if (en[5]) begin
         dabs_ff        <= dabs_in;
         sing_ff[PS-1]  <= (dabs_in == '0) || ((dabs_in >> (2 * F)) < DW'(thr_ff));
      end
      for (int s = PS; s < NS; s++) begin
         if (en[s]) sing_ff[s] <= sing_ff[s-1];
      end
   end

   for (genvar k = 0; k < 9; k++) begin : g_div
      m3inv_div u_div (
         .clock  (clock),
         .en     (en[NS-1:PS]),
         .num    (num_ff[k]),
         .den    (dabs_ff),
         .neg    (neg_ff[k]),
         .zero   (sing_ff[PS-1]),
         .result (res[k])
      );
   end

   assign rsp_r0c0     = $signed(res[0]);
   assign rsp_r0c1     = $signed(res[1]);
   assign rsp_r0c2     = $signed(res[2]);
   assign rsp_r1c0     = $signed(res[3]);
   assign rsp_r1c1     = $signed(res[4]);
   assign rsp_r1c2     = $signed(res[5]);
   assign rsp_r2c0     = $signed(res[6]);
   assign rsp_r2c1     = $signed(res[7]);
   assign rsp_r2c2     = $signed(res[8]);
   assign rsp_singular = sing_ff[NS-1];

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready) else $error("req_ready low while receiver ready");
   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("req_ready low with an empty output stage");
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_r0c0 == 0 && rsp_r1c1 == 0 && rsp_r2c2 == 0)
      else $error("singular result with nonzero elements");
endmodule

// ===== bench/tb.sv =====
// Self-checking bench for matrix3_inverse: directed and random matrices, exact
// predictor of the inverse, threshold register sweeps and flow-control stress.
// Depends on m3inv_pkg and the matrix3_inverse RTL.
`timescale 1ns / 1ps
module tb;
   localparam int LATENCY = m3inv_pkg::NUM_STAGES + 6;

   typedef logic signed [m3inv_pkg::WORD_BITS-1:0] elem_type;
   typedef elem_type mat_type [9];
   typedef struct {
      mat_type elem;
      logic sing;
   } inverse_type;
   typedef struct {
      mat_type m;
      logic known;
      inverse_type res;
   } stim_row_type;

   logic clock, reset;
   logic csr_write_enable;
   logic [m3inv_pkg::THR_W-1:0] csr_det_threshold;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   elem_type req_m [9];
   elem_type rsp_m [9];
   logic rsp_singular;

   logic [m3inv_pkg::THR_W-1:0] threshold;
   inverse_type pending_inverses[$];
   int errors, matrices_sent, inverses_seen, singular_seen, saturated_seen;
   int send_idle_pct, recv_stall_pct;
   logic hold_off;

   matrix3_inverse uut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_det_threshold(csr_det_threshold),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_r0c0(req_m[0]), .req_r0c1(req_m[1]), .req_r0c2(req_m[2]),
      .req_r1c0(req_m[3]), .req_r1c1(req_m[4]), .req_r1c2(req_m[5]),
      .req_r2c0(req_m[6]), .req_r2c1(req_m[7]), .req_r2c2(req_m[8]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_r0c0(rsp_m[0]), .rsp_r0c1(rsp_m[1]), .rsp_r0c2(rsp_m[2]),
      .rsp_r1c0(rsp_m[3]), .rsp_r1c1(rsp_m[4]), .rsp_r1c2(rsp_m[5]),
      .rsp_r2c0(rsp_m[6]), .rsp_r2c1(rsp_m[7]), .rsp_r2c2(rsp_m[8]),
      .rsp_singular(rsp_singular)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #500ms;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic inverse_type invert_matrix(mat_type m,
                                                 logic [m3inv_pkg::THR_W-1:0] thr);
      logic signed [199:0] x [9];
      logic signed [199:0] cof [9];
      logic signed [199:0] det, dabs, num, q, lim;
      inverse_type r;
      for (int i = 0; i < 9; i++) x[i] = m[i];
      for (int k = 0; k < 9; k++)
         cof[k] = x[m3inv_pkg::COF_IDX[k][0]] * x[m3inv_pkg::COF_IDX[k][1]]
                - x[m3inv_pkg::COF_IDX[k][2]] * x[m3inv_pkg::COF_IDX[k][3]];
      det = x[0] * cof[0] + x[1] * cof[3] + x[2] * cof[6];
      dabs = det < 0 ? -det : det;
      r.sing = (dabs == 0) || ((dabs >>> (2 * m3inv_pkg::FRAC_BITS)) < thr);
      lim = 200'sd1 <<< (m3inv_pkg::WORD_BITS - 1);
      for (int k = 0; k < 9; k++) begin
         if (r.sing) begin
            r.elem[k] = '0;
         end else begin
            num = (cof[k] < 0 ? -cof[k] : cof[k]) <<< (2 * m3inv_pkg::FRAC_BITS);
            q = num / dabs;
            if ((cof[k] < 0) != (det < 0)) begin
               if (q > lim) q = lim;
               r.elem[k] = elem_type'(-q);
            end else begin
               if (q > lim - 1) q = lim - 1;
               r.elem[k] = elem_type'(q);
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t: mismatch on %s: got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_inverses.size() == 0) begin
            report_mismatch("unexpected transaction", 1, 0);
         end else begin
            inverse_type want;
            want = pending_inverses.pop_front();
            for (int k = 0; k < 9; k++)
               if (rsp_m[k] !== want.elem[k])
                  report_mismatch($sformatf("element %0d", k), rsp_m[k], want.elem[k]);
            if (rsp_singular !== want.sing)
               report_mismatch("singular", rsp_singular, want.sing);
            inverses_seen++;
            if (want.sing) singular_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_matrix(mat_type m);
      inverse_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      for (int i = 0; i < 9; i++) req_m[i] <= m[i];
      do @(posedge clock); while (!req_ready);
      want = invert_matrix(m, threshold);
      for (int k = 0; k < 9; k++)
         if (!want.sing && (want.elem[k] == elem_type'(32'h7fffffff) ||
                            want.elem[k] == elem_type'(32'h80000000))) saturated_seen++;
      pending_inverses.push_back(want);
      matrices_sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_inverses.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_threshold(logic [m3inv_pkg::THR_W-1:0] value);
      drain();
      csr_write_enable <= 1;
      csr_det_threshold <= value;
      @(posedge clock);
      csr_write_enable <= 0;
      threshold = value;
   endtask

   function automatic elem_type random_elem();
      case ($urandom_range(5))
         0: return elem_type'($urandom);
         1: return elem_type'($signed($urandom_range(8 << m3inv_pkg::FRAC_BITS))
                              - (4 << m3inv_pkg::FRAC_BITS));
         2: return $urandom_range(1) ? elem_type'(32'h7fffffff) : elem_type'(32'h80000000);
         3: return elem_type'($signed($urandom_range(40)) - 20);
         default: return elem_type'($signed($urandom_range(1 << 20)) - (1 << 19));
      endcase
   endfunction

   function automatic mat_type random_matrix();
      mat_type m;
      for (int i = 0; i < 9; i++) m[i] = random_elem();
      if ($urandom_range(9) == 0)
         for (int c = 0; c < 3; c++) m[6 + c] = m[c];
      return m;
   endfunction

   localparam elem_type ONE = elem_type'(1 << m3inv_pkg::FRAC_BITS);
   localparam elem_type MAXV = elem_type'(32'h7fffffff);
   localparam elem_type MINV = elem_type'(32'h80000000);
   localparam mat_type ZERO_M = '{default: '0};
   localparam mat_type ID_M = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
   localparam mat_type NID_M = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};
   localparam inverse_type SING_R = '{elem: '{default: '0}, sing: 1'b1};
   localparam inverse_type ID_R = '{elem: ID_M, sing: 1'b0};
   localparam inverse_type NID_R = '{elem: NID_M, sing: 1'b0};

   stim_row_type directed [] = '{
      '{ZERO_M, 1, SING_R},
      '{ID_M, 1, ID_R},
      '{NID_M, 1, NID_R},
      '{'{ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, ONE}, 1, SING_R},
      '{'{1, 0, 0, 0, 1, 0, 0, 0, 1}, 1, SING_R},
      '{'{MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV}, 0, SING_R},
      '{'{MINV, 0, 0, 0, MINV, 0, 0, 0, MINV}, 0, SING_R},
      '{'{MAXV, MINV, 0, MINV, MAXV, 0, 0, 0, MAXV}, 0, SING_R},
      '{'{256, 0, 0, 0, 256, 0, 0, 0, 256}, 0, SING_R},
      '{'{2 * ONE, ONE, 0, ONE, 3 * ONE, ONE, 0, ONE, 4 * ONE}, 0, SING_R},
      '{'{MINV, MAXV, MINV, MAXV, MINV, MAXV, -ONE, 5, MINV}, 0, SING_R},
      '{'{-1, -1, -1, -1, -1, -1, -1, -1, -1}, 0, SING_R},
      '{'{32'h55555555, 32'haaaaaaaa, 7, 3, 32'h55555555, 9, 1, 2, 32'haaaaaaaa},
        0, SING_R}
   };

   initial begin
      mat_type m;
      logic [m3inv_pkg::THR_W-1:0] thr_set [5] = '{0, 31'h7fffffff, 31'd2, 31'd100, 31'd1};
      reset = 1;
      csr_write_enable = 0;
      csr_det_threshold = '0;
      req_valid = 0;
      for (int i = 0; i < 9; i++) req_m[i] = '0;
      hold_off = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      threshold = 1;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (directed[r]) begin
         send_matrix(directed[r].m);
         if (directed[r].known) begin
            pending_inverses.pop_back();
            pending_inverses.push_back(directed[r].res);
         end
      end

      for (int phase = 0; phase < 5; phase++) begin
         write_threshold(thr_set[phase]);
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            3: begin send_idle_pct = 35; recv_stall_pct = 35; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         if (phase == 4) begin
            fork
               begin
                  hold_off = 1;
                  repeat (200) @(posedge clock);
                  hold_off = 0;
               end
            join_none
         end
         for (int n = 0; n < 88; n++) begin
            m = random_matrix();
            send_matrix(m);
            if (n == 40) drain();
         end
      end

      drain();
      $display("Sent %0d matrices, checked %0d inverses (%0d singular, %0d saturated).",
               matrices_sent, inverses_seen, singular_seen, saturated_seen);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
